// ===== hdl/led_blink_code_sequencer_unit_macros.svh =====
// Assertion macros of the LED blink-code sequencer checker.
`ifndef LED_BLINK_CODE_SEQUENCER_UNIT_MACROS_SVH
`define LED_BLINK_CODE_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge unless dis is high.
`define LBCS_ASSERT_IMPLY(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("lbcs: implication check failed");

// Next-cycle implication, checked on every rising edge unless dis is high.
`define LBCS_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("lbcs: next-cycle check failed");

`endif

// ===== hdl/lbcs_pkg.sv =====
// Shared types, constants and helper functions of the LED blink-code sequencer.
`timescale 1ns / 1ps
package lbcs_pkg;

    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_SET     = 2'd1,
        KIND_BLINK   = 2'd2,
        KIND_READOUT = 2'd3
    } kind_t;

    // Digit positions of the readout; DIGIT_PASSED means the units digit is done.
    localparam logic [1:0] DIGIT_HUNDREDS = 2'd2;
    localparam logic [1:0] DIGIT_TENS     = 2'd1;
    localparam logic [1:0] DIGIT_UNITS    = 2'd0;
    localparam logic [1:0] DIGIT_PASSED   = 2'd3;

    localparam logic [2:0] LAST_OCTET = 3'd3;

    localparam logic [15:0] OCTET_PAUSE_MS  = 16'd250;
    localparam logic [15:0] ZERO_PERIOD_MS  = 16'd100;
    localparam logic [15:0] ZERO_DELAY_MS   = 16'd500;
    localparam logic [15:0] DIGIT_PERIOD_MS = 16'd500;
    localparam logic [15:0] DIGIT_DELAY_MS  = 16'd1000;
    localparam logic [15:0] FIRST_PERIOD_MS = 16'd50;
    localparam logic [15:0] ELAPSED_MAX     = 16'hFFFF;

    localparam int TDATA_IN_W  = 80;
    localparam int TDATA_OUT_W = 8;

    typedef struct packed {
        logic [31:0] ip_address;
        logic [15:0] start_delay_ms;
        logic [15:0] period_ms;
        logic [7:0]  times;
        logic        level;
        kind_t       kind;
    } item_t;

    typedef struct packed {
        logic [1:0] hundreds;
        logic [3:0] tens;
        logic [3:0] units;
    } digits_t;

    typedef struct packed {
        logic         pin_out;
        logic         toggle_level;
        logic         last_set_level;
        logic [8:0]   toggles_left;
        logic [15:0]  blink_period;
        logic [15:0]  pending_delay;
        logic [15:0]  elapsed_ms;
        logic         readout_active;
        digits_t [3:0] octet_digits;
        logic [1:0]   digit_position;
        logic [2:0]   octet_position;
    } state_t;

    // Result fields, highest bit first.
    typedef struct packed {
        logic blinking;
        logic readout_busy;
        logic pin_level;
    } result_t;

    // Decimal digits of one octet: compare for hundreds, reciprocal multiply for tens.
    function automatic digits_t to_digits(input logic [7:0] v);
        digits_t     d;
        logic [7:0]  rem;
        logic [15:0] prod;
        logic [7:0]  tens_x10;
        begin
            if (v >= 8'd200) begin
                d.hundreds = 2'd2;
                rem        = v - 8'd200;
            end else if (v >= 8'd100) begin
                d.hundreds = 2'd1;
                rem        = v - 8'd100;
            end else begin
                d.hundreds = 2'd0;
                rem        = v;
            end
            // rem stays below 100, where (rem * 205) >> 11 equals rem / 10.
            prod     = {8'd0, rem} * 16'd205;
            d.tens   = prod[14:11];
            tens_x10 = {1'b0, d.tens, 3'b000};
            tens_x10 = tens_x10 + {3'b000, d.tens, 1'b0};
            d.units  = 4'(rem - tens_x10);
            return d;
        end
    endfunction

    // Begins a blink run: pin low, fresh delay, period and toggle count.
    function automatic state_t start_run(input state_t s, input logic [7:0] count,
                                         input logic [15:0] period,
                                         input logic [15:0] delay);
        state_t r;
        begin
            r               = s;
            r.pin_out       = 1'b0;
            r.pending_delay = delay;
            r.blink_period  = period;
            r.toggles_left  = {count, 1'b1};
            r.elapsed_ms    = 16'd0;
            return r;
        end
    endfunction

    localparam state_t STATE_RESET = '{
        pin_out:        1'b0,
        toggle_level:   1'b0,
        last_set_level: 1'b0,
        toggles_left:   9'd0,
        blink_period:   16'd0,
        pending_delay:  16'd0,
        elapsed_ms:     16'd0,
        readout_active: 1'b0,
        octet_digits:   '0,
        digit_position: DIGIT_HUNDREDS,
        octet_position: 3'd0
    };

endpackage

// ===== hdl/lbcs_in_reg.sv =====
// Input register stage of the LED blink-code sequencer.
`timescale 1ns / 1ps
module lbcs_in_reg
    import lbcs_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  take,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready = !valid_reg || take;

    always_comb begin
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hdl/lbcs_step.sv =====
// Next-state logic of the LED blink-code sequencer for one item.
`timescale 1ns / 1ps
module lbcs_step
    import lbcs_pkg::*;
(
    input  item_t  item,
    input  state_t state_cur,
    output state_t state_nxt
);

    logic [15:0] elapsed_inc;
    logic [8:0]  toggles_dec;
    logic [2:0]  oct;
    logic [15:0] pause;
    logic [1:0]  pos;
    digits_t     od;
    logic [3:0]  digit;

    assign elapsed_inc = (state_cur.elapsed_ms == ELAPSED_MAX) ? state_cur.elapsed_ms
                                                               : state_cur.elapsed_ms + 16'd1;
    assign toggles_dec = state_cur.toggles_left - 9'd1;

    // Readout advance: move to the next octet once the units digit is done.
    always_comb begin
        if (state_cur.digit_position == DIGIT_PASSED) begin
            oct   = state_cur.octet_position + 3'd1;
            pause = OCTET_PAUSE_MS;
            pos   = DIGIT_HUNDREDS;
        end else begin
            oct   = state_cur.octet_position;
            pause = 16'd0;
            pos   = state_cur.digit_position;
        end
        od = state_cur.octet_digits[oct[1:0]];
        case (pos)
            DIGIT_HUNDREDS: digit = {2'b00, od.hundreds};
            DIGIT_TENS:     digit = od.tens;
            default:        digit = od.units;
        endcase
    end

    always_comb begin
        state_nxt = state_cur;
        case (item.kind)
            KIND_TICK: begin
                state_nxt.elapsed_ms = elapsed_inc;
                if (state_cur.pending_delay != 16'd0) begin
                    if (elapsed_inc >= state_cur.pending_delay) begin
                        state_nxt.pending_delay = 16'd0;
                        state_nxt.elapsed_ms    = 16'd0;
                    end
                end else if (state_cur.toggles_left != 9'd0 &&
                             elapsed_inc >= state_cur.blink_period) begin
                    state_nxt.elapsed_ms   = 16'd0;
                    state_nxt.toggle_level = !state_cur.toggle_level;
                    state_nxt.pin_out      = !state_cur.toggle_level;
                    state_nxt.toggles_left = toggles_dec;
                    if (toggles_dec == 9'd0) begin
                        if (!state_cur.readout_active) begin
                            state_nxt.pin_out = state_cur.last_set_level;
                        end else if (oct > LAST_OCTET) begin
                            state_nxt.readout_active = 1'b0;
                            state_nxt.digit_position = DIGIT_HUNDREDS;
                            state_nxt.octet_position = 3'd0;
                            state_nxt.pin_out        = state_cur.last_set_level;
                        end else begin
                            if (digit == 4'd0) begin
                                state_nxt = start_run(state_nxt, 8'd1, ZERO_PERIOD_MS,
                                                      ZERO_DELAY_MS + pause);
                            end else begin
                                state_nxt = start_run(state_nxt, {4'd0, digit},
                                                      DIGIT_PERIOD_MS, DIGIT_DELAY_MS + pause);
                            end
                            state_nxt.octet_position = oct;
                            if (state_cur.digit_position == DIGIT_PASSED) begin
                                state_nxt.digit_position = DIGIT_TENS;
                            end else begin
                                state_nxt.digit_position = state_cur.digit_position - 2'd1;
                            end
                        end
                    end
                end
            end
            KIND_SET: begin
                state_nxt.toggles_left   = 9'd0;
                state_nxt.toggle_level   = item.level;
                state_nxt.last_set_level = item.level;
                state_nxt.pin_out        = item.level;
            end
            KIND_BLINK: begin
                if (!state_cur.readout_active) begin
                    state_nxt = start_run(state_cur, item.times, item.period_ms,
                                          item.start_delay_ms);
                end
            end
            KIND_READOUT: begin
                if (!state_cur.readout_active) begin
                    state_nxt = start_run(state_cur, item.ip_address[31:24],
                                          FIRST_PERIOD_MS, 16'd0);
                    state_nxt.octet_digits[0] = to_digits(item.ip_address[31:24]);
                    state_nxt.octet_digits[1] = to_digits(item.ip_address[23:16]);
                    state_nxt.octet_digits[2] = to_digits(item.ip_address[15:8]);
                    state_nxt.octet_digits[3] = to_digits(item.ip_address[7:0]);
                    state_nxt.digit_position  = DIGIT_HUNDREDS;
                    state_nxt.octet_position  = 3'd0;
                    state_nxt.readout_active  = 1'b1;
                end
            end
            default: begin
                state_nxt = state_cur;
            end
        endcase
    end

endmodule

// ===== hdl/lbcs_out_reg.sv =====
// Result register stage of the LED blink-code sequencer.
`timescale 1ns / 1ps
module lbcs_out_reg
    import lbcs_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  result_t                result,
    output logic                   can_load,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_load = !valid_reg || m_tready;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {(TDATA_OUT_W - $bits(result_t))'(0), result_reg};

endmodule

// ===== hdl/led_blink_code_sequencer_unit.sv =====
// Top level of the LED blink-code sequencer: handshake stages and sequencer state.
`timescale 1ns / 1ps
//
//  Channel   Direction  Payload (lowest bit first)
//  s_*       in         tuser: kind; tdata: level, times, period_ms, start_delay_ms, ip_address
//  m_*       out        tdata: pin_level, readout_busy, blinking
//
// Each transaction is held first in the input register and then in the result
// register. The sequencer state is updated by a single pass of next-state logic,
// which sustains one transaction per clock cycle while results are taken.
// Reset (synchronous, aresetn low) empties both stages and returns the LED to off.
// A stall on the result side holds the result; the input register still takes one
// more transaction and then s_tready falls until the result is taken.
module led_blink_code_sequencer_unit
    import lbcs_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // level, times, period_ms, start_delay_ms,
                                              // ip_address, zero padding
    input  logic [1:0]             s_tuser,   // kind
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata    // pin_level, readout_busy, blinking, padding
);

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    can_load;
    logic    take;
    state_t  state_reg;
    state_t  state_next;
    result_t result;

    // Unpack the slave transaction into the item fields.
    always_comb begin
        s_item.kind           = kind_t'(s_tuser);
        s_item.level          = s_tdata[0];
        s_item.times          = s_tdata[8:1];
        s_item.period_ms      = s_tdata[24:9];
        s_item.start_delay_ms = s_tdata[40:25];
        s_item.ip_address     = s_tdata[72:41];
    end

    lbcs_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // The held item is processed as soon as the result register has room.
    assign take = item_valid && can_load;

    lbcs_step u_step (
        .item      (item),
        .state_cur (state_reg),
        .state_nxt (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (take) begin
            state_reg <= state_next;
        end
    end

    // The result reports the state left behind by this item.
    assign result.pin_level    = state_next.pin_out;
    assign result.readout_busy = state_next.readout_active;
    assign result.blinking     = (state_next.toggles_left != 9'd0);

    lbcs_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (take),
        .result   (result),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== hdl/lbcs_checker.sv =====
// Port-level checker of the LED blink-code sequencer and its bind statement.
`timescale 1ns / 1ps
`include "led_blink_code_sequencer_unit_macros.svh"
module lbcs_checker
    import lbcs_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [TDATA_OUT_W-1:0] m_tdata
);

    // A stalled result stays valid and unchanged.
    `LBCS_ASSERT_NEXT(a_out_hold, aclk, !aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // With the result register empty, the block always takes a new transaction.
    `LBCS_ASSERT_IMPLY(a_ready_when_empty, aclk, !aresetn, !m_tvalid, s_tready)

    // Padding bits of a result are zero.
    `LBCS_ASSERT_IMPLY(a_out_pad, aclk, !aresetn, m_tvalid, m_tdata[7:3] == 5'd0)

    // Reset leaves no result pending.
    `LBCS_ASSERT_NEXT(a_reset_empty, aclk, 1'b0, !aresetn, !m_tvalid)

endmodule

bind led_blink_code_sequencer_unit lbcs_checker u_lbcs_checker (.*);

// ===== verif/led_pattern_checker.sv =====
// Checker for the LED blink-code sequencer: predicts each result and compares it.
`timescale 1ns / 1ps
module led_pattern_checker
    import lbcs_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,
    input  logic [1:0]             s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [TDATA_OUT_W-1:0] m_tdata,
    output int                     mismatches,
    output int                     outstanding,
    output logic                   readout_on
);

    // Command word on s_tdata, lowest field last in the list.
    typedef struct packed {
        logic [TDATA_IN_W-74:0] pad;
        logic [31:0]            ip_address;
        logic [15:0]            start_delay_ms;
        logic [15:0]            period_ms;
        logic [7:0]             times;
        logic                   level;
    } cmd_word_t;

    localparam int HUNDREDS_POS = 2;
    localparam int TENS_POS     = 1;
    localparam int UNITS_POS    = 0;

    // Predicted sequencer state.
    logic        led_q       = 1'b0;
    logic        toggle_lvl  = 1'b0;
    logic        set_lvl     = 1'b0;
    logic [8:0]  toggles_rem = '0;
    logic [15:0] run_period  = '0;
    logic [15:0] delay_rem   = '0;
    logic [15:0] elapsed     = '0;
    logic        readout_q   = 1'b0;
    logic [31:0] addr_q      = '0;
    int          digit_pos   = HUNDREDS_POS;
    logic [2:0]  octet_pos   = '0;

    result_t pin_states_due[$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    assign readout_on = readout_q;

    function automatic logic [7:0] octet_of(input logic [2:0] idx);
        logic [31:0] w;
        w = addr_q >> ((3 - idx[1:0]) * 8);
        return w[7:0];
    endfunction

    task automatic begin_run(input logic [7:0] count, input logic [15:0] per,
                             input logic [15:0] dly);
        led_q       = 1'b0;
        delay_rem   = dly;
        run_period  = per;
        toggles_rem = {count, 1'b1};
        elapsed     = '0;
    endtask

    // Moves the address readout to its next digit, or ends it after the last octet.
    task automatic next_digit();
        logic [15:0] pause;
        logic [7:0]  v;
        logic [7:0]  d;
        pause = '0;
        if (digit_pos < UNITS_POS) begin
            digit_pos = HUNDREDS_POS;
            octet_pos = octet_pos + 3'd1;
            pause     = OCTET_PAUSE_MS;
        end
        if (octet_pos > LAST_OCTET) begin
            readout_q = 1'b0;
            digit_pos = HUNDREDS_POS;
            octet_pos = '0;
            led_q     = set_lvl;
        end else begin
            v = octet_of(octet_pos);
            case (digit_pos)
                HUNDREDS_POS: d = v / 100;
                TENS_POS:     d = (v / 10) % 10;
                default:      d = v % 10;
            endcase
            if (d == 0) begin
                begin_run(8'd1, ZERO_PERIOD_MS, ZERO_DELAY_MS + pause);
            end else begin
                begin_run(d, DIGIT_PERIOD_MS, DIGIT_DELAY_MS + pause);
            end
            digit_pos--;
        end
    endtask

    task automatic advance_ms();
        if (elapsed != ELAPSED_MAX) elapsed++;
        if (delay_rem != 0) begin
            if (elapsed >= delay_rem) begin
                delay_rem = '0;
                elapsed   = '0;
            end
        end else if (toggles_rem != 0 && elapsed >= run_period) begin
            elapsed     = '0;
            toggle_lvl  = ~toggle_lvl;
            led_q       = toggle_lvl;
            toggles_rem = toggles_rem - 9'd1;
            if (toggles_rem == 0) begin
                if (readout_q) next_digit();
                else led_q = set_lvl;
            end
        end
    endtask

    task automatic predict_led(input kind_t kind, input cmd_word_t w);
        result_t r;
        case (kind)
            KIND_TICK: advance_ms();
            KIND_SET: begin
                toggles_rem = '0;
                toggle_lvl  = w.level;
                set_lvl     = w.level;
                led_q       = w.level;
            end
            KIND_BLINK: begin
                if (!readout_q) begin_run(w.times, w.period_ms, w.start_delay_ms);
            end
            KIND_READOUT: begin
                if (!readout_q) begin
                    addr_q    = w.ip_address;
                    digit_pos = HUNDREDS_POS;
                    octet_pos = '0;
                    readout_q = 1'b1;
                    begin_run(octet_of(3'd0), FIRST_PERIOD_MS, 16'd0);
                end
            end
        endcase
        r.pin_level    = led_q;
        r.readout_busy = readout_q;
        r.blinking     = (toggles_rem != 0);
        pin_states_due.push_back(r);
    endtask

    task automatic check_field(input string name, input logic want, input logic got);
        if (want !== got) begin
            $display("%0t: %s expected %0b, got %0b", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : watch
        result_t want;
        result_t got;
        if (!aresetn) begin
            led_q       = 1'b0;
            toggle_lvl  = 1'b0;
            set_lvl     = 1'b0;
            toggles_rem = '0;
            run_period  = '0;
            delay_rem   = '0;
            elapsed     = '0;
            readout_q   = 1'b0;
            addr_q      = '0;
            digit_pos   = HUNDREDS_POS;
            octet_pos   = '0;
            pin_states_due.delete();
        end else begin
            if (s_tvalid && s_tready) predict_led(kind_t'(s_tuser), cmd_word_t'(s_tdata));
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[2:0]);
                if (pin_states_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %b", $time, got);
                    mismatches++;
                end else begin
                    want = pin_states_due.pop_front();
                    check_field("pin_level", want.pin_level, got.pin_level);
                    check_field("readout_busy", want.readout_busy, got.readout_busy);
                    check_field("blinking", want.blinking, got.blinking);
                end
            end
        end
        outstanding = pin_states_due.size();
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the LED blink-code sequencer: stimulus, handshake idling and verdict.
`timescale 1ns / 1ps
module tb;
    import lbcs_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 10;
    // The limit leaves room for the slowest correct run, with the longest idling on
    // every transaction, which is mostly ticks of the address readouts.
    localparam int CYCLE_LIMIT  = 20_000_000;
    localparam int RANDOM_ITEMS = 550;
    localparam int DRAIN_CYCLES = 8;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata;   // level, times, period_ms, start_delay_ms, ip_address
    logic [1:0]             s_tuser;   // kind
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;   // pin_level, readout_busy, blinking

    int   mismatches;
    int   outstanding;
    logic readout_on;

    bit   calm;         // set for the closing part: no idling on either side
    bit   counting;     // counts transactions toward the random budget
    int   counted;
    int   cycles;

    led_blink_code_sequencer_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    led_pattern_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .readout_on  (readout_on)
    );

    initial begin
        aclk = 1'b0;
        forever #HALF_PERIOD aclk = ~aclk;
    end

    // Run-length guard: the run is failed if it has not finished by the limit.
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: ready in stretches of random length, broken by random stall
    // bursts. In the closing part the receiver is always ready.
    initial begin
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge aclk);
            end
        end
    end

    // Presents one transaction at a falling edge and returns at the falling edge
    // after it was accepted. s_tvalid stays high so that a following transaction
    // goes out back to back; every path that waits lowers it first.
    task automatic send(input kind_t kind, input logic lvl, input logic [7:0] times,
                        input logic [15:0] per, input logic [15:0] dly,
                        input logic [31:0] ip);
        if (!calm && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, ip, dly, per, times, lvl};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (counting) counted++;
        @(negedge aclk);
    endtask

    // A tick carries random values in the fields it ignores.
    task automatic tick();
        send(KIND_TICK, 1'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), $urandom);
    endtask

    task automatic run_ticks(input int n);
        repeat (n) tick();
    endtask

    task automatic set_level(input logic lvl);
        send(KIND_SET, lvl, 8'($urandom), 16'($urandom), 16'($urandom), $urandom);
    endtask

    task automatic blink(input logic [7:0] times, input logic [15:0] per,
                         input logic [15:0] dly);
        send(KIND_BLINK, 1'($urandom), times, per, dly, $urandom);
    endtask

    task automatic readout(input logic [31:0] ip);
        send(KIND_READOUT, 1'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), ip);
    endtask

    // Ticks a blink run needs from its command to its last toggle.
    function automatic int blink_ticks(input int times, input int per, input int dly);
        return dly + (2 * times + 1) * (per == 0 ? 1 : per);
    endfunction

    // The sender holds off until every expected result has been taken.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
    endtask

    // A complete address readout. Right after the start a blink and a second
    // readout arrive; both must be ignored. Ticks then run until the predicted
    // readout has finished, with rare ignored commands mixed in. None of it
    // counts toward the random budget.
    task automatic play_readout(input logic [31:0] ip);
        bit keep;
        keep     = counting;
        counting = 1'b0;
        drain();
        readout(ip);
        blink(8'd1, 16'd1, 16'd1);
        readout($urandom);
        while (readout_on) begin
            if ($urandom_range(0, 499) == 0) begin
                if ($urandom_range(0, 1) == 0) blink(8'($urandom), 16'($urandom), 16'($urandom));
                else readout($urandom);
            end else begin
                tick();
            end
        end
        run_ticks($urandom_range(0, 3));
        counting = keep;
    endtask

    initial begin : stimulus
        int   pick;
        int   full;
        int   n;
        int   readouts_done;
        logic [7:0]  t;
        logic [15:0] p;
        logic [15:0] d;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        calm     = 1'b0;
        counting = 1'b0;
        counted  = 0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed part: idle tick, both levels, zero period, start delays of one
        // and more, the largest blink fields, a restart in the middle of a run.
        tick();
        set_level(1'b1);
        set_level(1'b0);
        blink(8'd0, 16'd0, 16'd0);
        run_ticks(2);
        blink(8'd3, 16'd2, 16'd3);
        run_ticks(blink_ticks(3, 2, 3) + 2);
        // With the level set high the first toggle of a run drives the pin low.
        set_level(1'b1);
        blink(8'd1, 16'd0, 16'd1);
        run_ticks(blink_ticks(1, 0, 1) + 1);
        blink(8'hFF, 16'hFFFF, 16'hFFFF);
        run_ticks(3);
        set_level(1'b0);
        blink(8'd2, 16'hFFFF, 16'd0);
        run_ticks(2);
        blink(8'd2, 16'd1, 16'd0);
        run_ticks(blink_ticks(2, 1, 0) + 1);
        set_level(1'b1);

        // Address readout 3.255.9.100: zero digits, a hundreds digit of two, the
        // largest digit, and the restore of the high set level at the end.
        play_readout(32'h03FF_0964);

        // Random part: mostly well-formed blink runs with random content, some
        // level changes, noise and interrupted runs. Two full readouts are
        // spread over it.
        counting      = 1'b1;
        counted       = 0;
        readouts_done = 0;
        while (counted < RANDOM_ITEMS) begin
            if (readouts_done < 2 && counted >= (readouts_done + 1) * RANDOM_ITEMS / 3) begin
                play_readout({4'd0, 4'($urandom), 24'($urandom)});
                readouts_done++;
            end
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                t = $urandom_range(0, 4);
                p = $urandom_range(0, 4);
                d = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 6)) : 16'd0;
                if ($urandom_range(0, 9) == 0) begin
                    t = $urandom;
                    p = 16'd0;
                end
                blink(t, p, d);
                full = blink_ticks(t, p, d);
                n    = ($urandom_range(0, 4) == 0) ? $urandom_range(0, full)
                                                   : full + $urandom_range(0, 3);
                run_ticks(n);
            end else if (pick < 75) begin
                set_level(1'($urandom));
                run_ticks($urandom_range(0, 3));
            end else if (pick < 90) begin
                send(kind_t'($urandom_range(KIND_TICK, KIND_BLINK)), 1'($urandom),
                     8'($urandom), 16'($urandom), 16'($urandom), $urandom);
                run_ticks($urandom_range(0, 2));
            end else begin
                // A run cut short by a new blink or a level change.
                blink($urandom_range(1, 4), $urandom_range(1, 3), $urandom_range(0, 3));
                run_ticks($urandom_range(0, 6));
                if ($urandom_range(0, 1) == 0) blink($urandom_range(0, 2), 16'd0, 16'd0);
                else set_level(1'($urandom));
                run_ticks($urandom_range(0, 3));
            end
        end

        // Closing part, no idling: a level change in the middle of a readout stops
        // it for good, so later blinks and readouts stay ignored.
        calm = 1'b1;
        readout(32'h0102_0304);
        run_ticks(200);
        set_level(1'b1);
        run_ticks(5);
        blink(8'd2, 16'd1, 16'd0);
        readout($urandom);
        run_ticks(3);
        set_level(1'b0);
        run_ticks(3);

        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/lbcs_pkg.sv
hdl/lbcs_in_reg.sv
hdl/lbcs_step.sv
hdl/lbcs_out_reg.sv
hdl/led_blink_code_sequencer_unit.sv
hdl/lbcs_checker.sv
verif/led_pattern_checker.sv
verif/tb.sv
